// ----- design/mdt_pkg.sv -----
// Package for the MAC address learning table.
// Holds beat and entry types, field widths and the rolling-address nibble codes.
// No dependencies.
package mdt_pkg;

    localparam int MAC_W  = 48;
    localparam int RSSI_W = 8;
    localparam int SLOT_W = 7;

    localparam int DEFAULT_TABLE_DEPTH = 128;

    localparam logic [3:0] ROLL_NIB_2 = 4'h2;
    localparam logic [3:0] ROLL_NIB_6 = 4'h6;
    localparam logic [3:0] ROLL_NIB_A = 4'hA;
    localparam logic [3:0] ROLL_NIB_E = 4'hE;

    typedef struct packed {
        logic [MAC_W-1:0]         mac_addr;
        logic signed [RSSI_W-1:0] rssi;
    } in_beat_t;

    typedef struct packed {
        logic              is_new;
        logic [SLOT_W-1:0] slot;
        logic              rolling;
        logic              dump_request;
    } out_beat_t;

    typedef struct packed {
        logic [MAC_W-1:0]  mac;
        logic [RSSI_W-1:0] rssi;
        logic              rolling;
    } entry_data_t;

    typedef struct packed {
        logic        valid;
        entry_data_t data;
    } entry_t;

endpackage

// ----- design/mac_dedup_table.sv -----
// Top level of the MAC address learning table: ring of entry cells, search control,
// fill pointer and result register. Depends on mdt_pkg and mdt_cell.
//
//  channel | ports                    | payload            | direction
//  --------+--------------------------+--------------------+----------
//  input   | s_valid, s_ready, s_data | mdt_pkg::in_beat_t | in
//  result  | m_valid, m_ready, m_data | mdt_pkg::out_beat_t| out
//
// Each beat is accepted, then the cell ring rotates once past the single comparator
// at its head, then the result is loaded.
// A new beat is accepted once the previous result sits in the output register.
// Reset clears all valid bits and the fill pointer directly; no clearing pass.
// A stalled result holds the block in its final step until the output register frees.
module mac_dedup_table #(
    parameter int TABLE_DEPTH = mdt_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  mdt_pkg::in_beat_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output mdt_pkg::out_beat_t m_data
);
    import mdt_pkg::*;

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int PW = $clog2(TABLE_DEPTH + 1);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SEARCH = 2'd1;
    localparam logic [1:0] ST_DONE   = 2'd2;

    function automatic logic is_rolling(input logic [MAC_W-1:0] mac);
        logic [3:0] nib;
        nib = mac[MAC_W-5 -: 4];
        return nib inside {ROLL_NIB_2, ROLL_NIB_6, ROLL_NIB_A, ROLL_NIB_E};
    endfunction

    logic [1:0]    state_reg, state_next;
    logic [IW-1:0] cnt_reg, cnt_next;
    logic          hit_reg, hit_next;
    logic [IW-1:0] hit_idx_reg, hit_idx_next;
    logic [PW-1:0] fill_ptr_reg, fill_ptr_next;
    in_beat_t      key_reg, key_next;
    logic          m_valid_reg, m_valid_next;
    out_beat_t     m_data_reg, m_data_next;

    entry_t        ring [TABLE_DEPTH];
    entry_data_t   load_data;
    logic          shift_en;
    logic          wr_en;
    logic          out_load;
    logic          full;
    logic          head_match;
    logic          key_roll;
    logic [IW-1:0] wr_idx;

    genvar gi;
    generate
        for (gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
            mdt_cell u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .shift_en  (shift_en),
                .load_en   (wr_en && (wr_idx == IW'(gi))),
                .shift_in  (ring[(gi + 1) % TABLE_DEPTH]),
                .load_data (load_data),
                .entry_out (ring[gi])
            );
        end
    endgenerate

    assign s_ready    = (state_reg == ST_IDLE);
    assign shift_en   = (state_reg == ST_SEARCH);
    assign head_match = ring[0].valid && (ring[0].data.mac == key_reg.mac_addr);
    assign key_roll   = is_rolling(key_reg.mac_addr);
    assign full       = (fill_ptr_reg >= PW'(TABLE_DEPTH));
    assign wr_idx     = full ? '0 : fill_ptr_reg[IW-1:0];
    assign out_load   = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);
    assign wr_en      = out_load && !hit_reg;

    assign load_data.mac     = key_reg.mac_addr;
    assign load_data.rssi    = key_reg.rssi;
    assign load_data.rolling = key_roll;

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        hit_next      = hit_reg;
        hit_idx_next  = hit_idx_reg;
        fill_ptr_next = fill_ptr_reg;
        key_next      = key_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    key_next   = s_data;
                    cnt_next   = '0;
                    hit_next   = 1'b0;
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (head_match && !hit_reg) begin
                    hit_next     = 1'b1;
                    hit_idx_next = cnt_reg;
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == IW'(TABLE_DEPTH - 1)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    m_valid_next        = 1'b1;
                    m_data_next.rolling = key_roll;
                    if (hit_reg) begin
                        m_data_next.is_new       = 1'b0;
                        m_data_next.slot         = SLOT_W'(hit_idx_reg);
                        m_data_next.dump_request = 1'b0;
                    end else begin
                        m_data_next.is_new       = 1'b1;
                        m_data_next.slot         = SLOT_W'(wr_idx);
                        m_data_next.dump_request = full;
                        fill_ptr_next            = PW'(wr_idx) + 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            hit_reg      <= 1'b0;
            fill_ptr_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            hit_reg      <= hit_next;
            fill_ptr_reg <= fill_ptr_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        hit_idx_reg <= hit_idx_next;
        key_reg     <= key_next;
        m_data_reg  <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_ptr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_ptr_reg <= PW'(TABLE_DEPTH))
        else $error("fill pointer beyond table depth");

    a_rise_after_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg) == ST_DONE)
        else $error("result raised outside final step");

    a_dump_only_new: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_data_reg.is_new |-> !m_data_reg.dump_request)
        else $error("dump flagged on a hit");

    a_dump_wraps: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en && full |=> fill_ptr_reg == PW'(1))
        else $error("pointer did not wrap on dump");

    a_ring_home: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> cnt_reg == '0 || cnt_reg == IW'(TABLE_DEPTH))
        else $error("ring not back in place at write");

endmodule

// ----- design/mdt_cell.sv -----
// One table cell: holds a single entry and passes it to its neighbor on shift.
// A direct load writes a new entry while the ring is at rest.
// Depends on mdt_pkg.
module mdt_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                shift_en,
    input  logic                load_en,
    input  mdt_pkg::entry_t     shift_in,
    input  mdt_pkg::entry_data_t load_data,
    output mdt_pkg::entry_t     entry_out
);
    import mdt_pkg::*;

    logic        valid_reg;
    logic        valid_next;
    entry_data_t data_reg;
    entry_data_t data_next;

    always_comb begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (shift_en) begin
            valid_next = shift_in.valid;
            data_next  = shift_in.data;
        end else if (load_en) begin
            valid_next = 1'b1;
            data_next  = load_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign entry_out.valid = valid_reg;
    assign entry_out.data  = data_reg;

endmodule
